FILE: hw/rtl/scc_pkg.sv
// Package with the shared types and constants of the sound channel claim block.
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

  localparam int unsigned NUM_CH = 8;
  localparam int unsigned CH_W   = $clog2(NUM_CH);
  localparam int unsigned VOL_W  = 7;
  localparam int unsigned SAMP_W = 8;
  localparam int unsigned PAN_W  = 8;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [PAN_W-1:0] PAN_FULL   = 8'd254;
  localparam logic [CH_W-1:0]  SCAN_FIRST = 3'd3;
  localparam logic [CH_W-1:0]  SCAN_LAST  = 3'd7;

  // Reset values of the configuration registers.
  localparam logic             RST_ENABLE    = 1'b1;
  localparam logic [VOL_W-1:0] RST_VOL_CAP   = 7'd127;
  localparam logic [CH_W-1:0]  RST_EXPL_CH   = 3'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_BID    = 2'd0,
    CMD_FORCE  = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE  = 2'd0,
    CFG_VOL_CAP = 2'd1,
    CFG_EXPL_CH = 2'd2,
    CFG_UNUSED  = 2'd3
  } cfg_idx_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sound_channel_claim.sv
// Top level of the sound channel claim block: mixer channel allocation with stealing.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake                 | Payload
// ----------+---------------------------+---------------------------------------------
// input     | start / busy              | in_cmd, in_channel, in_volume, in_sample_id,
//           |                           | in_pan
// result    | out_valid (strobe only)   | out_granted, out_granted_channel,
//           |                           | out_play_volume, out_play_sample,
//           |                           | out_pan_left, out_pan_right
// config    | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// A beat is taken at every clock edge where start is high and busy is low, so one
// command enters per clock. Its result passes the input register first; then the
// claim decision is made against the channel table and written to the result
// register in the same edge that updates the table.
// Reset is synchronous and active low; busy stays high for the first cycle after it.
// The receiver cannot stall, so out_valid is a one-cycle strobe for every beat.

module sound_channel_claim (
  input  wire logic                         clk,
  input  wire logic                         rst_n,

  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic [scc_pkg::CMD_W-1:0]    in_cmd,
  input  wire logic [scc_pkg::CH_W-1:0]     in_channel,
  input  wire logic [scc_pkg::VOL_W-1:0]    in_volume,
  input  wire logic [scc_pkg::SAMP_W-1:0]   in_sample_id,
  input  wire logic [scc_pkg::PAN_W-1:0]    in_pan,

  output      logic                         out_valid,
  output      logic                         out_granted,
  output      logic [scc_pkg::CH_W-1:0]     out_granted_channel,
  output      logic [scc_pkg::VOL_W-1:0]    out_play_volume,
  output      logic [scc_pkg::SAMP_W-1:0]   out_play_sample,
  output      logic [scc_pkg::PAN_W-1:0]    out_pan_left,
  output      logic [scc_pkg::PAN_W-1:0]    out_pan_right,

  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [scc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [scc_pkg::CFG_DATA_W-1:0] cfg_data
);

  import scc_pkg::*;

  // Control and configuration state.
  logic             busy_r;
  logic             in_vld_r;
  logic             out_vld_r;
  logic             enable_r;
  logic [VOL_W-1:0] vol_cap_r;
  logic [CH_W-1:0]  expl_ch_r;

  // Input register (payload, no reset).
  cmd_t              cmd_r;
  logic [CH_W-1:0]   ch_r;
  logic [VOL_W-1:0]  vol_r;
  logic [SAMP_W-1:0] samp_r;
  logic [PAN_W-1:0]  pan_r;

  // Channel table. Reset clears it, since idle channels and zero volumes are defined.
  logic [NUM_CH-1:0] busy_flags_r;
  logic [VOL_W-1:0]  claimed_vol_r [NUM_CH];
  logic [NUM_CH-1:0] busy_flags_nxt;
  logic [VOL_W-1:0]  claimed_vol_nxt [NUM_CH];

  // Result register.
  logic              granted_r;
  logic [CH_W-1:0]   gch_r;
  logic [VOL_W-1:0]  pvol_r;
  logic [SAMP_W-1:0] psamp_r;
  logic [PAN_W-1:0]  pleft_r;
  logic [PAN_W-1:0]  pright_r;

  // Decision logic.
  logic              accept;
  logic [VOL_W-1:0]  vol_clamped;
  logic [PAN_W-1:0]  pan_sat;
  logic [NUM_CH-1:0] may_take;
  logic              scan_hit;
  logic [CH_W-1:0]   scan_ch;
  logic              grant;
  logic [CH_W-1:0]   target;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      enable_r  <= RST_ENABLE;
      vol_cap_r <= RST_VOL_CAP;
      expl_ch_r <= RST_EXPL_CH;
    end else begin
      busy_r    <= 1'b0;
      in_vld_r  <= accept;
      out_vld_r <= in_vld_r;
      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ENABLE:  enable_r  <= cfg_data[0];
          CFG_VOL_CAP: vol_cap_r <= cfg_data[VOL_W-1:0];
          CFG_EXPL_CH: expl_ch_r <= cfg_data[CH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= cmd_t'(in_cmd);
      ch_r   <= in_channel;
      vol_r  <= in_volume;
      samp_r <= in_sample_id;
      pan_r  <= in_pan;
    end
  end

  assign vol_clamped = (vol_r > vol_cap_r) ? vol_cap_r : vol_r;
  assign pan_sat     = (pan_r > PAN_FULL) ? PAN_FULL : pan_r;

  // A channel may be taken when it is idle or its current sound is strictly quieter.
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      may_take[i] = !busy_flags_r[i] || (claimed_vol_r[i] < vol_clamped);
    end
  end

  // Explosion scan: the lowest channel from the first scan channel upward wins.
  always_comb begin
    scan_hit = 1'b0;
    scan_ch  = '0;
    for (int i = int'(SCAN_LAST); i >= int'(SCAN_FIRST); i--) begin
      if (may_take[i]) begin
        scan_hit = 1'b1;
        scan_ch  = CH_W'(i);
      end
    end
  end

  always_comb begin
    grant  = 1'b0;
    target = ch_r;
    if (in_vld_r && enable_r) begin
      unique case (cmd_r)
        CMD_FORCE: grant = 1'b1;
        CMD_BID: begin
          if (ch_r == expl_ch_r) begin
            grant  = scan_hit;
            target = scan_ch;
          end else begin
            grant = may_take[ch_r];
          end
        end
        default: grant = 1'b0;
      endcase
    end
  end

  always_comb begin
    busy_flags_nxt = busy_flags_r;
    for (int i = 0; i < NUM_CH; i++) begin
      claimed_vol_nxt[i] = claimed_vol_r[i];
    end
    if (in_vld_r && (cmd_r == CMD_FINISH)) begin
      busy_flags_nxt[ch_r]  = 1'b0;
      claimed_vol_nxt[ch_r] = '0;
    end else if (grant) begin
      busy_flags_nxt[target]  = 1'b1;
      claimed_vol_nxt[target] = vol_clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_flags_r <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        claimed_vol_r[i] <= '0;
      end
    end else begin
      busy_flags_r <= busy_flags_nxt;
      for (int i = 0; i < NUM_CH; i++) begin
        claimed_vol_r[i] <= claimed_vol_nxt[i];
      end
    end
  end

  // Refused bids, finish events, NOP commands and any command while disabled report all-zero fields.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      granted_r <= 1'b0;
    end else if (in_vld_r) begin
      granted_r <= grant;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      gch_r    <= grant ? target : '0;
      pvol_r   <= grant ? vol_clamped : '0;
      psamp_r  <= grant ? samp_r : '0;
      pleft_r  <= grant ? (PAN_FULL - pan_sat) : '0;
      pright_r <= grant ? pan_sat : '0;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_granted         = out_vld_r && granted_r;
  assign out_granted_channel = gch_r;
  assign out_play_volume     = pvol_r;
  assign out_play_sample     = psamp_r;
  assign out_pan_left        = pleft_r;
  assign out_pan_right       = pright_r;

  // Every result strobe belongs to a beat that passed through the input register.
  a_out_follows_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_vld_r))
    else $error("result strobe without a preceding input beat");

  // A reported grant is already recorded in the channel table.
  a_grant_recorded: assert property (@(posedge clk) disable iff (!rst_n)
    out_granted |-> (busy_flags_r[out_granted_channel] &&
                     claimed_vol_r[out_granted_channel] == out_play_volume))
    else $error("granted channel not marked busy with its volume");

  // The pan pair always sums to full scale on a grant.
  a_pan_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_granted |-> (PAN_W'(out_pan_left + out_pan_right) == PAN_FULL))
    else $error("pan pair does not sum to full scale");

  // A result without a grant carries zero fields.
  a_refusal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |-> (out_granted_channel == '0 &&
      out_play_volume == '0 && out_play_sample == '0 &&
      out_pan_left == '0 && out_pan_right == '0))
    else $error("refused result carries nonzero fields");

  // Free idle channels never hold a claimed volume.
  a_idle_zero_vol: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !busy_flags_r[ch_r]) |-> (claimed_vol_r[ch_r] == '0))
    else $error("idle channel holds a claimed volume");

endmodule

`default_nettype wire
